// File: design/bdc_pkg.sv
// Shared types and constants for the button debounce / click / long-press unit.
// No dependencies; every other design file but bdc_ifs imports this package.
package bdc_pkg;

    // Button slots
    localparam int unsigned NUM_BTN = 3;
    localparam logic [1:0] BTN_PREV   = 2'd0;
    localparam logic [1:0] BTN_NEXT   = 2'd1;
    localparam logic [1:0] BTN_SELECT = 2'd2;

    // Configuration register indexes and reset values
    localparam logic [1:0]  CFG_FLIPPED       = 2'd0;
    localparam logic [1:0]  CFG_DEBOUNCE_MS   = 2'd1;
    localparam logic [1:0]  CFG_LONG_PRESS_MS = 2'd2;
    localparam logic [15:0] DEBOUNCE_MS_RST   = 16'd30;
    localparam logic [15:0] LONG_PRESS_MS_RST = 16'd800;

    // Button levels (active low)
    localparam logic LVL_PRESSED  = 1'b0;
    localparam logic LVL_RELEASED = 1'b1;

    typedef enum logic [1:0] {
        REQ_SAMPLE     = 2'd0,
        REQ_READ_CLEAR = 2'd1,
        REQ_INJECT     = 2'd2,
        REQ_CLEAR_ALL  = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_CLICK = 2'd1,
        EV_LONG  = 2'd2
    } t_event;

    // Per-button debounce state
    typedef struct packed {
        logic        raw;
        logic        stable;
        logic [31:0] change_time;
        logic [31:0] press_time;
        logic        long_done;
    } t_btn_state;

    // Event raised by one button in one sample
    typedef struct packed {
        logic   set;
        t_event code;
    } t_btn_evt;

endpackage

// File: design/bdc_ifs.sv
// Handshake channels of the button debounce unit: request, response, config write.
// Stand-alone; no package dependency.
interface bdc_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [31:0] now_ms;
    logic       level_prev;
    logic       level_next;
    logic       level_select;
    logic [1:0] target_button;
    logic [1:0] inject_event;

    modport source (output valid, req_type, now_ms, level_prev, level_next, level_select,
                    target_button, inject_event, input ready);
    modport sink   (input valid, req_type, now_ms, level_prev, level_next, level_select,
                    target_button, inject_event, output ready);
endinterface

interface bdc_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] prev_event;
    logic [1:0] next_event;
    logic [1:0] select_event;

    modport source (output valid, prev_event, next_event, select_event, input ready);
    modport sink   (input valid, prev_event, next_event, select_event, output ready);
endinterface

interface bdc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  addr;
    logic [15:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

// File: design/button_debounce_click_longpress_unit.sv
// Top level of the three-button debounce unit with click and long-press latching.
// Depends on bdc_pkg, bdc_ifs (channels) and bdc_button.
//
// Takes one request per clock on i_req while o_rsp keeps up, and returns exactly
// one response per request on o_rsp, in order. A request is captured in an input
// register; once the response register is free or being taken, a single pass of
// logic updates the three button state sets (on a sample) and the latched events
// and loads the response register. The response carries the latched events as
// they were before that request. Each button's pass is one 32-bit wrapping
// subtract and compare for debounce and one for hold time. Configuration writes
// on i_cfg are always taken; indexes 0 (flipped), 1 (debounce_ms) and 2
// (long_press_ms) are used, others are ignored. Write them only while idle.
module button_debounce_click_longpress_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    bdc_req_if.sink   i_req,
    bdc_rsp_if.source o_rsp,
    bdc_cfg_if.sink   i_cfg
);
    import bdc_pkg::*;

    // configuration
    logic        r_flipped;
    logic [15:0] r_debounce_ms;
    logic [15:0] r_long_press_ms;

    // input register
    logic        r_in_vld;
    t_req_type   r_req_type;
    logic [31:0] r_now;
    logic [NUM_BTN-1:0] r_level;
    logic [1:0]  r_target;
    logic [1:0]  r_inject;

    // button state and latched events
    t_btn_state  r_btn [NUM_BTN];
    t_btn_state  n_btn [NUM_BTN];
    t_btn_evt    btn_evt [NUM_BTN];
    t_event      r_pending [NUM_BTN];
    t_event      n_pending [NUM_BTN];
    logic [1:0]  evt_target [NUM_BTN];

    // response register
    logic        r_out_vld;
    t_event      r_out_ev [NUM_BTN];

    logic        in_xfer;
    logic        advance;

    assign advance     = r_in_vld && (!r_out_vld || o_rsp.ready);
    assign i_req.ready = !r_in_vld || advance;
    assign in_xfer     = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flipped       <= 1'b0;
            r_debounce_ms   <= DEBOUNCE_MS_RST;
            r_long_press_ms <= LONG_PRESS_MS_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.addr)
                CFG_FLIPPED:       r_flipped       <= i_cfg.data[0];
                CFG_DEBOUNCE_MS:   r_debounce_ms   <= i_cfg.data;
                CFG_LONG_PRESS_MS: r_long_press_ms <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // capture a request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_xfer) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_req_type          <= t_req_type'(i_req.req_type);
            r_now               <= i_req.now_ms;
            r_level[BTN_PREV]   <= i_req.level_prev;
            r_level[BTN_NEXT]   <= i_req.level_next;
            r_level[BTN_SELECT] <= i_req.level_select;
            r_target            <= i_req.target_button;
            r_inject            <= i_req.inject_event;
        end
    end

    // per-button debounce logic
    for (genvar g = 0; g < NUM_BTN; g++) begin : g_btn
        bdc_button u_btn (
            .i_level         (r_level[g]),
            .i_now           (r_now),
            .i_debounce_ms   (r_debounce_ms),
            .i_long_press_ms (r_long_press_ms),
            .i_state         (r_btn[g]),
            .o_state         (n_btn[g]),
            .o_event         (btn_evt[g])
        );
    end

    // swap prev and next event targets when flipped
    assign evt_target[BTN_PREV]   = r_flipped ? BTN_NEXT : BTN_PREV;
    assign evt_target[BTN_NEXT]   = r_flipped ? BTN_PREV : BTN_NEXT;
    assign evt_target[BTN_SELECT] = BTN_SELECT;

    // next latched events
    always_comb begin
        for (int b = 0; b < NUM_BTN; b++) begin
            n_pending[b] = r_pending[b];
        end
        unique case (r_req_type)
            REQ_SAMPLE: begin
                for (int b = 0; b < NUM_BTN; b++) begin
                    if (btn_evt[b].set) begin
                        n_pending[evt_target[b]] = btn_evt[b].code;
                    end
                end
            end
            REQ_READ_CLEAR, REQ_CLEAR_ALL: begin
                for (int b = 0; b < NUM_BTN; b++) begin
                    n_pending[b] = EV_NONE;
                end
            end
            REQ_INJECT: begin
                // drop an unknown target or event code
                if (r_target <= BTN_SELECT && r_inject <= EV_LONG) begin
                    n_pending[r_target] = t_event'(r_inject);
                end
            end
            default: ;
        endcase
    end

    // update button state and events
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BTN; b++) begin
                r_btn[b]     <= '{raw: LVL_RELEASED, stable: LVL_RELEASED,
                                  change_time: 32'd0, press_time: 32'd0, long_done: 1'b0};
                r_pending[b] <= EV_NONE;
            end
        end else if (advance) begin
            for (int b = 0; b < NUM_BTN; b++) begin
                if (r_req_type == REQ_SAMPLE) begin
                    r_btn[b] <= n_btn[b];
                end
                r_pending[b] <= n_pending[b];
            end
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            for (int b = 0; b < NUM_BTN; b++) begin
                r_out_ev[b] <= r_pending[b];
            end
        end
    end

    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.prev_event   = r_out_ev[BTN_PREV];
    assign o_rsp.next_event   = r_out_ev[BTN_NEXT];
    assign o_rsp.select_event = r_out_ev[BTN_SELECT];

endmodule

// File: design/bdc_button.sv
// Next-state logic of one debounced button: debounce, press time, click / long press.
// Depends on bdc_pkg.
module bdc_button (
    input  logic               i_level,
    input  logic [31:0]        i_now,
    input  logic [15:0]        i_debounce_ms,
    input  logic [15:0]        i_long_press_ms,
    input  bdc_pkg::t_btn_state i_state,
    output bdc_pkg::t_btn_state o_state,
    output bdc_pkg::t_btn_evt   o_event
);
    import bdc_pkg::*;

    logic        raw_changed;
    logic [31:0] change_time;
    logic [31:0] since_change;
    logic        settled;
    logic [31:0] since_press;

    // restart the debounce timer on any raw change
    assign raw_changed  = (i_level != i_state.raw);
    assign change_time  = raw_changed ? i_now : i_state.change_time;
    assign since_change = i_now - change_time;
    assign settled      = (since_change > {16'd0, i_debounce_ms});
    // a fresh press leaves zero elapsed, which never exceeds the hold time
    assign since_press  = i_now - i_state.press_time;

    always_comb begin
        o_state             = i_state;
        o_state.raw         = i_level;
        o_state.change_time = change_time;
        o_event             = '{set: 1'b0, code: EV_NONE};
        if (settled) begin
            // accept the new debounced level
            if (i_level != i_state.stable) begin
                o_state.stable = i_level;
                if (i_level == LVL_PRESSED) begin
                    o_state.press_time = i_now;
                    o_state.long_done  = 1'b0;
                end else if (!i_state.long_done) begin
                    o_event = '{set: 1'b1, code: EV_CLICK};
                end
            end
            // latch one long press while held
            if (i_level == LVL_PRESSED && i_state.stable == LVL_PRESSED &&
                !i_state.long_done && since_press > {16'd0, i_long_press_ms}) begin
                o_event           = '{set: 1'b1, code: EV_LONG};
                o_state.long_done = 1'b1;
            end
        end
    end

endmodule

// File: design/bdc_checker.sv
// Port-level checks of the button debounce unit, bound to its top level.
// Depends on bdc_pkg and button_debounce_click_longpress_unit.
module bdc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_valid,
    input logic       i_req_ready,
    input logic       i_rsp_valid,
    input logic       i_rsp_ready,
    input logic [1:0] i_prev_event,
    input logic [1:0] i_next_event,
    input logic [1:0] i_select_event
);
    import bdc_pkg::*;

    // a reset leaves no response pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid right after reset");

    // every reported event is none, click or long press
    a_event_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_prev_event != 2'd3 && i_next_event != 2'd3 &&
                         i_select_event != 2'd3))
        else $error("undefined event code in response");

    // input back-pressure only comes from a stalled response
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req_ready |-> (i_rsp_valid && !i_rsp_ready))
        else $error("request stalled while response side is free");

    // hold a stalled response
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_prev_event) && $stable(i_next_event) &&
             $stable(i_select_event)))
        else $error("stalled response changed");

endmodule

bind button_debounce_click_longpress_unit bdc_checker u_bdc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_prev_event   (o_rsp.prev_event),
    .i_next_event   (o_rsp.next_event),
    .i_select_event (o_rsp.select_event)
);

// File: dv/button_debounce_click_longpress_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for button_debounce_click_longpress_unit: a directed stimulus table,
// then random phases under several register settings; responses checked against table or predictor.
// Depends on bdc_pkg, the bdc_ifs channel interfaces and the design top level.
module button_debounce_click_longpress_unit_tb;
    import bdc_pkg::*;

    localparam int unsigned HANG_LIMIT      = 5000;
    localparam int unsigned ITEMS_PER_PHASE = 180;
    localparam int unsigned NUM_PHASES      = 8;
    localparam int unsigned MAX_REPORTS     = 10;
    // Out-of-range codes: must leave the latched events untouched
    localparam logic [1:0]  BTN_NO_SLOT     = 2'd3;
    localparam logic [1:0]  EV_BAD_CODE     = 2'd3;
    // Index with no register behind it
    localparam logic [1:0]  CFG_UNUSED      = 2'd3;

    typedef struct packed {
        t_req_type   kind;
        logic [31:0] now;
        logic [2:0]  lvl;   // [0] prev, [1] next, [2] select
        logic [1:0]  tgt;
        logic [1:0]  code;
    } t_btn_req;

    typedef struct packed {
        t_event prev_ev;
        t_event next_ev;
        t_event sel_ev;
    } t_evt_set;

    typedef struct packed {
        t_btn_req rq;
        logic     typed;
        t_evt_set want;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bdc_req_if req_ch();
    bdc_rsp_if rsp_ch();
    bdc_cfg_if cfg_ch();

    button_debounce_click_longpress_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    t_evt_set    events_due[$];
    t_dir_row    dir_rows[$];
    int unsigned err_cnt   = 0;
    int unsigned hang_cnt  = 0;
    bit          no_idle   = 1'b0;

    // Register settings per random phase
    logic        ph_flip [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    logic [15:0] ph_deb  [NUM_PHASES] = '{16'd30, 16'd0, 16'd65535, 16'd5,
                                          16'd3, 16'd65535, 16'd0, 16'd30};
    logic [15:0] ph_lp   [NUM_PHASES] = '{16'd800, 16'd0, 16'd65535, 16'd40,
                                          16'd20, 16'd0, 16'd65535, 16'd800};

    // Predictor copy of the block's registers and per-button state
    logic        mdl_flip;
    logic [15:0] mdl_deb;
    logic [15:0] mdl_lp;
    logic        mdl_raw    [NUM_BTN];
    logic        mdl_stable [NUM_BTN];
    logic [31:0] mdl_chg    [NUM_BTN];
    logic [31:0] mdl_press  [NUM_BTN];
    logic        mdl_long   [NUM_BTN];
    t_event      mdl_evt    [NUM_BTN];

    // Stimulus generator state
    logic [31:0] sim_ms = 32'd0;
    logic        want_lvl [NUM_BTN] = '{1'b1, 1'b1, 1'b1};

    always #5 i_clk = ~i_clk;

    function automatic void flag_error(string msg);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) $display("%s", msg);
    endfunction

    // Swap prev and next targets under flip
    function automatic int unsigned event_slot(int unsigned b);
        if (mdl_flip && b < 2) return b ^ 1;
        return b;
    endfunction

    function automatic void debounce_btn(int unsigned b, logic lvl, logic [31:0] now);
        logic [31:0] settle;
        logic [31:0] held;
        // Restart the debounce timer on any raw change
        if (lvl != mdl_raw[b]) begin
            mdl_chg[b] = now;
            mdl_raw[b] = lvl;
        end
        settle = now - mdl_chg[b];
        if (settle > {16'd0, mdl_deb}) begin
            if (lvl != mdl_stable[b]) begin
                mdl_stable[b] = lvl;
                if (lvl == LVL_PRESSED) begin
                    mdl_press[b] = now;
                    mdl_long[b]  = 1'b0;
                end else if (!mdl_long[b]) begin
                    mdl_evt[event_slot(b)] = EV_CLICK;
                end
            end
            held = now - mdl_press[b];
            if (mdl_stable[b] == LVL_PRESSED && !mdl_long[b] && held > {16'd0, mdl_lp}) begin
                mdl_evt[event_slot(b)] = EV_LONG;
                mdl_long[b] = 1'b1;
            end
        end
    endfunction

    // Return the latched events ahead of this request, then apply it
    function automatic t_evt_set predict_events(t_btn_req rq);
        t_evt_set latched_now;
        latched_now.prev_ev = mdl_evt[BTN_PREV];
        latched_now.next_ev = mdl_evt[BTN_NEXT];
        latched_now.sel_ev  = mdl_evt[BTN_SELECT];
        case (rq.kind)
            REQ_SAMPLE: begin
                for (int unsigned b = 0; b < NUM_BTN; b++) debounce_btn(b, rq.lvl[b], rq.now);
            end
            REQ_READ_CLEAR, REQ_CLEAR_ALL: begin
                for (int unsigned b = 0; b < NUM_BTN; b++) mdl_evt[b] = EV_NONE;
            end
            default: begin
                if (rq.tgt != BTN_NO_SLOT && rq.code != EV_BAD_CODE)
                    mdl_evt[rq.tgt] = t_event'(rq.code);
            end
        endcase
        return latched_now;
    endfunction

    function automatic void add_row(t_req_type kind, logic [31:0] now, logic [2:0] lvl,
                                    logic [1:0] tgt, logic [1:0] code, int typed,
                                    t_event p_ev, t_event n_ev, t_event s_ev);
        t_dir_row row;
        row.rq.kind      = kind;
        row.rq.now       = now;
        row.rq.lvl       = lvl;
        row.rq.tgt       = tgt;
        row.rq.code      = code;
        row.typed        = (typed != 0);
        row.want.prev_ev = p_ev;
        row.want.next_ev = n_ev;
        row.want.sel_ev  = s_ev;
        dir_rows.push_back(row);
    endfunction

    // Offer one request, idling at random first; valid stays high after the transfer
    task automatic send_req(input t_btn_req rq, input logic typed, input t_evt_set want);
        t_evt_set calc;
        while (!no_idle && $urandom_range(99) < 37) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= rq.kind;
        req_ch.now_ms        <= rq.now;
        req_ch.level_prev    <= rq.lvl[0];
        req_ch.level_next    <= rq.lvl[1];
        req_ch.level_select  <= rq.lvl[2];
        req_ch.target_button <= rq.tgt;
        req_ch.inject_event  <= rq.code;
        do @(posedge i_clk); while (!req_ch.ready);
        calc = predict_events(rq);
        events_due.push_back(typed ? want : calc);
    endtask

    // Hold off the sender until every outstanding response has come back
    task automatic drain_rsp();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (events_due.size() != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        // Let the pipeline go quiet before touching a register
        repeat (4) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_FLIPPED:       mdl_flip = val[0];
            CFG_DEBOUNCE_MS:   mdl_deb  = val;
            CFG_LONG_PRESS_MS: mdl_lp   = val;
            default: ;
        endcase
    endtask

    // Stall the response side at random, except in the no-idle phase
    always @(posedge i_clk) begin
        rsp_ch.ready <= no_idle || ($urandom_range(99) >= 37);
    end

    // Compare each response transfer with the oldest expectation
    always @(posedge i_clk) begin : rsp_check
        t_evt_set exp_set;
        if (rsp_ch.valid && rsp_ch.ready) begin
            if (events_due.size() == 0) begin
                flag_error("unexpected response: no request outstanding");
            end else begin
                exp_set = events_due.pop_front();
                if (rsp_ch.prev_event !== exp_set.prev_ev ||
                    rsp_ch.next_event !== exp_set.next_ev ||
                    rsp_ch.select_event !== exp_set.sel_ev)
                    flag_error($sformatf(
                        "mismatch: prev/next/select exp %0d/%0d/%0d got %0d/%0d/%0d",
                        exp_set.prev_ev, exp_set.next_ev, exp_set.sel_ev,
                        rsp_ch.prev_event, rsp_ch.next_event, rsp_ch.select_event));
            end
        end
    end

    // Watchdog: end the run after too many cycles without any transfer
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            hang_cnt = 0;
        else
            hang_cnt++;
        if (hang_cnt >= HANG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        t_btn_req rq;
        int unsigned pick;
        logic [31:0] step;

        // Drive every block input to a known value
        i_rst_n              <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.req_type      <= REQ_SAMPLE;
        req_ch.now_ms        <= '0;
        req_ch.level_prev    <= LVL_RELEASED;
        req_ch.level_next    <= LVL_RELEASED;
        req_ch.level_select  <= LVL_RELEASED;
        req_ch.target_button <= BTN_PREV;
        req_ch.inject_event  <= EV_NONE;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.addr          <= CFG_FLIPPED;
        cfg_ch.data          <= '0;

        // Reset the predictor
        mdl_flip = 1'b0;
        mdl_deb  = DEBOUNCE_MS_RST;
        mdl_lp   = LONG_PRESS_MS_RST;
        for (int unsigned b = 0; b < NUM_BTN; b++) begin
            mdl_raw[b]    = LVL_RELEASED;
            mdl_stable[b] = LVL_RELEASED;
            mdl_chg[b]    = '0;
            mdl_press[b]  = '0;
            mdl_long[b]   = 1'b0;
            mdl_evt[b]    = EV_NONE;
        end

        // Directed table at reset settings: injects and clears, then a press that
        // wraps the millisecond counter, a long press and a click
        add_row(REQ_SAMPLE, 32'h0000_0000, 3'b111, BTN_PREV, EV_NONE, 1, EV_NONE, EV_NONE, EV_NONE);
        add_row(REQ_READ_CLEAR, 32'hFFFF_FFFF, 3'b000, BTN_NO_SLOT, EV_BAD_CODE, 1,
                EV_NONE, EV_NONE, EV_NONE);
        add_row(REQ_INJECT, 32'h0, 3'b111, BTN_PREV, EV_CLICK, 1, EV_NONE, EV_NONE, EV_NONE);
        add_row(REQ_INJECT, 32'h0, 3'b111, BTN_NEXT, EV_LONG, 1, EV_CLICK, EV_NONE, EV_NONE);
        add_row(REQ_INJECT, 32'h0, 3'b000, BTN_SELECT, EV_LONG, 1, EV_CLICK, EV_LONG, EV_NONE);
        add_row(REQ_INJECT, 32'h0, 3'b111, BTN_NO_SLOT, EV_CLICK, 1, EV_CLICK, EV_LONG, EV_LONG);
        add_row(REQ_INJECT, 32'h0, 3'b111, BTN_PREV, EV_BAD_CODE, 1, EV_CLICK, EV_LONG, EV_LONG);
        add_row(REQ_INJECT, 32'h0, 3'b111, BTN_PREV, EV_NONE, 1, EV_CLICK, EV_LONG, EV_LONG);
        add_row(REQ_CLEAR_ALL, 32'hFFFF_FFFF, 3'b000, BTN_SELECT, EV_LONG, 1,
                EV_NONE, EV_LONG, EV_LONG);
        add_row(REQ_READ_CLEAR, 32'h0, 3'b111, BTN_PREV, EV_NONE, 1, EV_NONE, EV_NONE, EV_NONE);
        add_row(REQ_SAMPLE, 32'hFFFF_FFF0, 3'b000, BTN_PREV, EV_NONE, 1,
                EV_NONE, EV_NONE, EV_NONE);
        add_row(REQ_SAMPLE, 32'h0000_000E, 3'b000, BTN_PREV, EV_NONE, 0, EV_NONE, EV_NONE, EV_NONE);
        add_row(REQ_SAMPLE, 32'h0000_000F, 3'b000, BTN_PREV, EV_NONE, 0, EV_NONE, EV_NONE, EV_NONE);
        add_row(REQ_SAMPLE, 32'h0000_032F, 3'b000, BTN_PREV, EV_NONE, 0, EV_NONE, EV_NONE, EV_NONE);
        add_row(REQ_SAMPLE, 32'h0000_0330, 3'b000, BTN_PREV, EV_NONE, 0, EV_NONE, EV_NONE, EV_NONE);
        add_row(REQ_SAMPLE, 32'h0000_0331, 3'b101, BTN_PREV, EV_NONE, 0, EV_NONE, EV_NONE, EV_NONE);
        add_row(REQ_SAMPLE, 32'h0000_0350, 3'b101, BTN_PREV, EV_NONE, 0, EV_NONE, EV_NONE, EV_NONE);
        add_row(REQ_READ_CLEAR, 32'h0, 3'b000, BTN_PREV, EV_NONE, 0, EV_NONE, EV_NONE, EV_NONE);
        add_row(REQ_SAMPLE, 32'h0000_0400, 3'b100, BTN_PREV, EV_NONE, 0, EV_NONE, EV_NONE, EV_NONE);
        add_row(REQ_SAMPLE, 32'h0000_0420, 3'b100, BTN_PREV, EV_NONE, 0, EV_NONE, EV_NONE, EV_NONE);
        add_row(REQ_SAMPLE, 32'h0000_0430, 3'b101, BTN_PREV, EV_NONE, 0, EV_NONE, EV_NONE, EV_NONE);
        add_row(REQ_SAMPLE, 32'h0000_0450, 3'b101, BTN_PREV, EV_NONE, 0, EV_NONE, EV_NONE, EV_NONE);
        add_row(REQ_READ_CLEAR, 32'h0, 3'b111, BTN_PREV, EV_NONE, 0, EV_NONE, EV_NONE, EV_NONE);
        add_row(REQ_SAMPLE, 32'hFFFF_FFFF, 3'b111, BTN_PREV, EV_NONE, 0,
                EV_NONE, EV_NONE, EV_NONE);
        add_row(REQ_READ_CLEAR, 32'h0, 3'b111, BTN_PREV, EV_NONE, 0, EV_NONE, EV_NONE, EV_NONE);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) send_req(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);

        // Random phases, each under its own register setting
        for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
            drain_rsp();
            write_reg(CFG_FLIPPED, {15'd0, ph_flip[ph]});
            write_reg(CFG_DEBOUNCE_MS, ph_deb[ph]);
            write_reg(CFG_LONG_PRESS_MS, ph_lp[ph]);
            if (ph == 5) write_reg(CFG_UNUSED, 16'($urandom));
            no_idle = (ph == 3);

            for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
                // In the first phase, pause the sender once mid-phase until the block has caught up
                if (ph == 0 && n == 90) drain_rsp();

                rq.now  = $urandom;
                rq.lvl  = 3'($urandom_range(7));
                rq.tgt  = 2'($urandom_range(3));
                rq.code = 2'($urandom_range(3));
                pick = $urandom_range(99);
                if (pick < 72)      rq.kind = REQ_SAMPLE;
                else if (pick < 84) rq.kind = REQ_READ_CLEAR;
                else if (pick < 93) rq.kind = REQ_INJECT;
                else                rq.kind = REQ_CLEAR_ALL;

                if (rq.kind == REQ_SAMPLE) begin
                    // Advance time in steps around the debounce and hold thresholds
                    pick = $urandom_range(99);
                    if (pick < 15)      step = $urandom_range(2);
                    else if (pick < 45) step = {16'd0, mdl_deb} + $urandom_range(3) - 1;
                    else if (pick < 70) step = {16'd0, mdl_lp} + $urandom_range(3) - 1;
                    else if (pick < 92) step = $urandom_range(64);
                    else                step = $urandom;
                    sim_ms = sim_ms + step;
                    rq.now = sim_ms;
                    // Hold levels for a while, with the odd bounce
                    for (int unsigned b = 0; b < NUM_BTN; b++) begin
                        if ($urandom_range(99) < 20) want_lvl[b] = ~want_lvl[b];
                        rq.lvl[b] = ($urandom_range(99) < 8) ? ~want_lvl[b] : want_lvl[b];
                    end
                end
                send_req(rq, 1'b0, '0);
            end
        end
        no_idle = 1'b0;

        drain_rsp();
        repeat (12) @(posedge i_clk);
        if (err_cnt == 0 && events_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
